[rtl/core/phase_difference_aoa_estimator_defines.svh]
// Assertion macros used by the checker of this block.
`ifndef PHASE_DIFFERENCE_AOA_ESTIMATOR_DEFINES_SVH
`define PHASE_DIFFERENCE_AOA_ESTIMATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDAOA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdaoa assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PDAOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdaoa assertion failed");

`endif

[rtl/core/pdaoa_pkg.sv]
`timescale 1ns / 1ps
package pdaoa_pkg;

   localparam int PHASE_W   = 16;
   localparam int SUM_W     = 20;
   localparam int CNT_W     = 5;
   localparam int N_W       = 4;
   localparam int RATIO_W   = 16;
   localparam int MAX_ANT   = 16;
   localparam int ANG_W     = 14;
   localparam int MAG_W     = 15;
   localparam int DIV_W     = 32;
   localparam int DVS_W     = 7;
   localparam int DCNT_W    = 5;

   localparam logic [MAG_W-1:0] QUARTER    = 15'd16384;
   localparam logic [30:0]      ONE_Q30    = 31'h4000_0000;
   localparam logic [30:0]      TWO_PI_LO  = 31'd1216271633;
   localparam logic [2:0]       TWO_PI_HI  = 3'd6;
   localparam logic [15:0]      RATIO_INIT = 16'd8192;

   // Configuration register indexes.
   localparam logic CSR_DIFF_MODE = 1'b0;
   localparam logic CSR_RATIO     = 1'b1;

   typedef struct packed {
      logic signed [PHASE_W-1:0] phase;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [PHASE_W-1:0] angle;
      logic                      too_few;
      logic                      too_many;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // Denominators of the nested sine polynomial, innermost first.
   function automatic logic [DVS_W-1:0] taylor_divisor(input logic [1:0] stage);
      logic [DVS_W-1:0] d;
      case (stage)
         2'd0:    d = 7'd72;
         2'd1:    d = 7'd42;
         2'd2:    d = 7'd20;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

endpackage

[rtl/core/pdaoa_div.sv]
`timescale 1ns / 1ps
module pdaoa_div (
   input  logic                   clock,
   input  logic                   reset,
   input  pdaoa_pkg::div_req_type div_req,
   output pdaoa_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [pdaoa_pkg::DCNT_W-1:0]       cnt_ff, cnt_in;
   logic [pdaoa_pkg::DIV_W-1:0]        work_ff, work_in;
   logic [pdaoa_pkg::DVS_W-1:0]        rem_ff, rem_in;
   logic [pdaoa_pkg::DVS_W-1:0]        dvs_ff, dvs_in;
   logic [pdaoa_pkg::DVS_W:0]          trial;
   logic [pdaoa_pkg::DVS_W:0]          diff;
   logic                               fits;

   // One restoring step per cycle: the quotient bit shifts in behind the dividend.
   assign trial = {rem_ff, work_ff[pdaoa_pkg::DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         work_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[pdaoa_pkg::DIV_W-2:0], fits};
         rem_in  = fits ? diff[pdaoa_pkg::DVS_W-1:0] : trial[pdaoa_pkg::DVS_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = work_ff;

endmodule

[rtl/core/phase_difference_aoa_estimator.sv]
`timescale 1ns / 1ps
// A word without last is taken and leaves the input ready for the next word.
// A word with last stalls the input until its result word is out: one quotient for the
// averaged sine, then 14 trial angles, each holding four quotients of the shared
// bit-serial divider. A saturated sine skips the angle search and fewer than two phases
// skip all division; a result stall can hold either. Reset (synchronous, active high)
// clears sums, counts and handshakes and loads diff_mode 1 and ratio 8192.
module phase_difference_aoa_estimator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pdaoa_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pdaoa_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b0_0000_0001,
      S_SCALE = 9'b0_0000_0010,
      S_QDIV  = 9'b0_0000_0100,
      S_ARG   = 9'b0_0000_1000,
      S_SQR   = 9'b0_0001_0000,
      S_TDIV  = 9'b0_0010_0000,
      S_PROD  = 9'b0_0100_0000,
      S_FIN   = 9'b0_1000_0000,
      S_WAIT  = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic                                mode_ff, mode_in;
   logic [pdaoa_pkg::RATIO_W-1:0]       ratio_ff, ratio_in;
   logic [pdaoa_pkg::PHASE_W-1:0]       ref_ff, ref_in;
   logic [pdaoa_pkg::PHASE_W-1:0]       prev_ff, prev_in;
   logic signed [pdaoa_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [pdaoa_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                                over_ff, over_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   pdaoa_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic signed [pdaoa_pkg::SUM_W-1:0]  snap_ff, snap_in;
   logic [pdaoa_pkg::N_W-1:0]           n_ff, n_in;
   logic                                few_ff, few_in;
   logic                                many_ff, many_in;
   logic [29:0]                         target_ff, target_in;
   logic [pdaoa_pkg::ANG_W-1:0]         a_ff, a_in;
   logic [pdaoa_pkg::ANG_W-1:0]         bit_ff, bit_in;
   logic [30:0]                         x_ff, x_in;
   logic [31:0]                         x2_ff, x2_in;
   logic [30:0]                         t_ff, t_in;
   logic [1:0]                          stage_ff, stage_in;
   logic [pdaoa_pkg::MAG_W-1:0]         mag_ff, mag_in;

   pdaoa_pkg::div_req_type              div_req;
   pdaoa_pkg::div_rsp_type              div_rsp;

   logic                                accept;
   logic [pdaoa_pkg::PHASE_W-1:0]       base;
   logic [pdaoa_pkg::PHASE_W-1:0]       wrapped;
   logic [pdaoa_pkg::CNT_W-1:0]         count_new;
   logic signed [pdaoa_pkg::SUM_W-1:0]  sum_new;
   logic                                over_new;
   logic [pdaoa_pkg::SUM_W-1:0]         snap_mag;
   logic [35:0]                         scaled;
   logic [pdaoa_pkg::ANG_W-1:0]         cand;
   logic [44:0]                         arg_lo;
   logic [48:0]                         arg_full;
   logic [61:0]                         sq_full;
   logic [62:0]                         poly_full;
   logic [61:0]                         sine_full;
   logic                                out_free;

   pdaoa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Wrapped difference against the first or the previous phase of the snapshot.
   assign base    = mode_ff ? prev_ff : ref_ff;
   assign wrapped = req_data.phase - base;

   // Arithmetic of the angle search.
   assign cand      = a_ff | bit_ff;
   assign snap_mag  = snap_ff[pdaoa_pkg::SUM_W-1] ? (pdaoa_pkg::SUM_W)'(-snap_ff)
                                                   : snap_ff;
   assign scaled    = 36'(snap_mag) * 36'(ratio_ff) + {20'd0, n_ff, 12'd0};
   assign arg_lo    = 45'(cand) * 45'(pdaoa_pkg::TWO_PI_LO);
   assign arg_full  = 49'(arg_lo) + {17'(cand) * 17'(pdaoa_pkg::TWO_PI_HI), 32'd0};
   assign sq_full   = 62'(x_ff) * 62'(x_ff);
   assign poly_full = 63'(x2_ff) * 63'(t_ff);
   assign sine_full = 62'(x_ff) * 62'(t_ff);

   // Snapshot accumulation and the control of the end-of-snapshot computation.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ratio_in     = ratio_ff;
      ref_in       = ref_ff;
      prev_in      = prev_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      over_in      = over_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      snap_in      = snap_ff;
      n_in         = n_ff;
      few_in       = few_ff;
      many_in      = many_ff;
      target_in    = target_ff;
      a_in         = a_ff;
      bit_in       = bit_ff;
      x_in         = x_ff;
      x2_in        = x2_ff;
      t_in         = t_ff;
      stage_in     = stage_ff;
      mag_in       = mag_ff;
      div_req      = '0;
      count_new    = count_ff;
      sum_new      = sum_ff;
      over_new     = over_ff;

      if (csr_write) begin
         unique case (csr_index)
            pdaoa_pkg::CSR_DIFF_MODE: mode_in  = csr_data[0];
            pdaoa_pkg::CSR_RATIO:     ratio_in = csr_data;
            default:                  mode_in  = mode_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff == '0) begin
                  ref_in    = req_data.phase;
                  prev_in   = req_data.phase;
                  count_new = (pdaoa_pkg::CNT_W)'(1);
               end else if (count_ff < (pdaoa_pkg::CNT_W)'(pdaoa_pkg::MAX_ANT)) begin
                  sum_new   = sum_ff + (pdaoa_pkg::SUM_W)'($signed(wrapped));
                  prev_in   = req_data.phase;
                  count_new = count_ff + 1'b1;
               end else begin
                  over_new = 1'b1;
               end
               if (req_data.last) begin
                  snap_in  = sum_new;
                  n_in     = (pdaoa_pkg::N_W)'(count_new - 1'b1);
                  few_in   = count_new < (pdaoa_pkg::CNT_W)'(2);
                  many_in  = over_new;
                  mag_in   = '0;
                  sum_in   = '0;
                  count_in = '0;
                  over_in  = 1'b0;
                  state_in = (count_new < (pdaoa_pkg::CNT_W)'(2)) ? S_WAIT : S_SCALE;
               end else begin
                  sum_in   = sum_new;
                  count_in = count_new;
                  over_in  = over_new;
               end
            end
         end
         S_SCALE: begin
            div_req.start    = 1'b1;
            div_req.dividend = (pdaoa_pkg::DIV_W)'(scaled[35:13]);
            div_req.divisor  = (pdaoa_pkg::DVS_W)'(n_ff);
            state_in         = S_QDIV;
         end
         S_QDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= 32'd32768) begin
                  mag_in   = pdaoa_pkg::QUARTER;
                  state_in = S_WAIT;
               end else begin
                  target_in = {div_rsp.quotient[14:0], 15'd0};
                  a_in      = '0;
                  bit_in    = {1'b1, {(pdaoa_pkg::ANG_W-1){1'b0}}};
                  state_in  = S_ARG;
               end
            end
         end
         S_ARG: begin
            x_in     = arg_full[48:18];
            state_in = S_SQR;
         end
         S_SQR: begin
            x2_in            = sq_full[61:30];
            div_req.start    = 1'b1;
            div_req.dividend = sq_full[61:30];
            div_req.divisor  = pdaoa_pkg::taylor_divisor(2'd0);
            stage_in         = 2'd0;
            state_in         = S_TDIV;
         end
         S_TDIV: begin
            if (div_rsp.done) begin
               t_in     = pdaoa_pkg::ONE_Q30 - div_rsp.quotient[30:0];
               state_in = (stage_ff == 2'd3) ? S_FIN : S_PROD;
            end
         end
         S_PROD: begin
            div_req.start    = 1'b1;
            div_req.dividend = poly_full[61:30];
            div_req.divisor  = pdaoa_pkg::taylor_divisor(stage_ff + 2'd1);
            stage_in         = stage_ff + 2'd1;
            state_in         = S_TDIV;
         end
         S_FIN: begin
            if ({1'b0, sine_full[60:30]} <= {2'd0, target_in}) begin
               a_in = cand;
            end
            bit_in = bit_ff >> 1;
            if (bit_ff == (pdaoa_pkg::ANG_W)'(1)) begin
               mag_in   = {1'b0, a_in};
               state_in = S_WAIT;
            end else begin
               state_in = S_ARG;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.angle    = snap_ff[pdaoa_pkg::SUM_W-1]
                                      ? 16'd0 - {1'b0, mag_ff} : {1'b0, mag_ff};
               rsp_data_in.too_few  = few_ff;
               rsp_data_in.too_many = many_ff;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b1;
         ratio_ff     <= pdaoa_pkg::RATIO_INIT;
         ref_ff       <= '0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         ratio_ff     <= ratio_in;
         ref_ff       <= ref_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      snap_ff     <= snap_in;
      n_ff        <= n_in;
      few_ff      <= few_in;
      many_ff     <= many_in;
      target_ff   <= target_in;
      a_ff        <= a_in;
      bit_ff      <= bit_in;
      x_ff        <= x_in;
      x2_ff       <= x2_in;
      t_ff        <= t_in;
      stage_ff    <= stage_in;
      mag_ff      <= mag_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/pdaoa_checker.sv]
`timescale 1ns / 1ps
`include "phase_difference_aoa_estimator_defines.svh"
module pdaoa_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input pdaoa_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input pdaoa_pkg::rsp_type rsp_data,
   input logic               csr_write,
   input logic               csr_index,
   input logic [15:0]        csr_data
);

   // A stalled result word holds.
   `PDAOA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A word inside a snapshot leaves the input ready; a closing word starts the computation.
   `PDAOA_ASSERT_NEXT(a_mid_ready, clock, reset, req_valid && !req_stall && !req_data.last, !req_stall)
   `PDAOA_ASSERT_NEXT(a_last_busy, clock, reset, req_valid && !req_stall && req_data.last, req_stall)

   // Short snapshots give a zero angle, and every angle stays within a quarter turn.
   `PDAOA_ASSERT_IMPL(a_angle_ok, clock, reset, rsp_valid, ($signed(rsp_data.angle) <= 16'sd16384) && ($signed(rsp_data.angle) >= -16'sd16384) && (!rsp_data.too_few || rsp_data.angle == 16'd0))

endmodule

bind phase_difference_aoa_estimator pdaoa_checker u_pdaoa_checker (.*);

[verif/tb_phase_difference_aoa_estimator.sv]
`timescale 1ns / 1ps
module tb_phase_difference_aoa_estimator;

   localparam int WORD_TARGET = 1650;
   localparam int IDLE_LIMIT  = 30000;

   // Tracks the snapshot state and holds the angles still to come out.
   class aoa_scoreboard;
      bit                 adjacent_mode;
      logic [15:0]        ratio;
      logic [15:0]        first_phase;
      logic [15:0]        last_phase;
      longint             phase_sum;
      int                 phase_cnt;
      bit                 dropped;
      pdaoa_pkg::rsp_type angle_queue[$];
      int                 errors;

      function void clear();
         adjacent_mode = 1'b1;
         ratio         = pdaoa_pkg::RATIO_INIT;
         first_phase   = '0;
         last_phase    = '0;
         phase_sum     = 0;
         phase_cnt     = 0;
         dropped       = 1'b0;
         angle_queue.delete();
         errors        = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] value);
         if (idx == pdaoa_pkg::CSR_DIFF_MODE) adjacent_mode = value[0];
         else ratio = value;
      endfunction

      // Sine of an angle code in Q30, nested polynomial with truncation.
      function longint unsigned sine_q30(longint unsigned a);
         longint unsigned x, x2, t;
         x  = (a * 64'd26986075409) >> 18;
         x2 = (x * x) >> 30;
         t  = 64'h4000_0000 - x2 / 72;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 42;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 20;
         t  = 64'h4000_0000 - ((x2 * t) >> 30) / 6;
         return (x * t) >> 30;
      endfunction

      function longint arcsine(longint unsigned s);
         longint unsigned a, cand;
         if (s >= 32768) return 16384;
         a = 0;
         for (longint unsigned b = 8192; b != 0; b = b >> 1) begin
            cand = a | b;
            if (cand < 16384 && sine_q30(cand) <= (s << 15)) a = cand;
         end
         return longint'(a);
      endfunction

      function void note_word(pdaoa_pkg::req_type w);
         logic [15:0]        diff;
         longint unsigned    mag, num, den, s;
         longint             ang;
         pdaoa_pkg::rsp_type r;
         if (phase_cnt == 0) begin
            first_phase = w.phase;
            last_phase  = w.phase;
            phase_cnt   = 1;
         end else if (phase_cnt < pdaoa_pkg::MAX_ANT) begin
            diff = w.phase - (adjacent_mode ? last_phase : first_phase);
            phase_sum += longint'($signed(diff));
            last_phase = w.phase;
            phase_cnt++;
         end else begin
            dropped = 1'b1;
         end
         if (!w.last) return;
         ang = 0;
         if (phase_cnt >= 2) begin
            mag = (phase_sum < 0) ? -phase_sum : phase_sum;
            num = (mag * ratio) << 15;
            den = longint'(phase_cnt - 1) << 28;
            s   = (num + den / 2) / den;
            ang = arcsine(s);
            if (phase_sum < 0) ang = -ang;
         end
         r.angle    = ang[15:0];
         r.too_few  = (phase_cnt < 2);
         r.too_many = dropped;
         angle_queue = {angle_queue, r};
         phase_cnt = 0;
         phase_sum = 0;
         dropped   = 1'b0;
      endfunction

      function void check(pdaoa_pkg::rsp_type got);
         pdaoa_pkg::rsp_type want;
         if (angle_queue.size() == 0) begin
            $error("unexpected result word angle=%0d", $signed(got.angle));
            errors++;
            return;
         end
         want = angle_queue.pop_front();
         if (got.angle !== want.angle) begin
            $error("angle: expected %0d, actual %0d", $signed(want.angle), $signed(got.angle));
            errors++;
         end
         if (got.too_few !== want.too_few) begin
            $error("too_few: expected %0b, actual %0b", want.too_few, got.too_few);
            errors++;
         end
         if (got.too_many !== want.too_many) begin
            $error("too_many: expected %0b, actual %0b", want.too_many, got.too_many);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   pdaoa_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   pdaoa_pkg::rsp_type rsp_data;
   logic               csr_write;
   logic               csr_index;
   logic [15:0]        csr_data;

   aoa_scoreboard sb;
   int            words_sent;
   int            idle_cycles;
   int            stall_left;
   bit            no_gaps;

   phase_difference_aoa_estimator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Result side: random stall, checking and the idle watchdog.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         idle_cycles <= 0;
         stall_left  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (no_gaps || $urandom_range(0, 9) < 6) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                      : $urandom_range(0, 3);
         end
      end
   end

   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Sends one word and holds it until it is taken.
   task automatic send_word(logic [15:0] ph, logic lst);
      int gap;
      req_valid      <= 1'b1;
      req_data.phase <= ph;
      req_data.last  <= lst;
      do @(posedge clock); while (req_stall);
      sb.note_word('{phase: ph, last: lst});
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until the block is idle, then writes one register.
   task automatic write_reg(logic idx, logic [15:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.angle_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_write <= 1'b0;
   endtask

   task automatic send_snapshot(int len, logic [15:0] base, logic [15:0] step, int noise);
      logic [15:0] ph;
      for (int k = 0; k < len; k++) begin
         ph = 16'(base + step * k + $urandom_range(0, 2 * noise) - noise);
         send_word(ph, k == len - 1);
      end
   endtask

   initial begin
      int len;
      logic [15:0] step;
      sb = new();
      sb.clear();
      words_sent = 0;
      no_gaps    = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_write  = 1'b0;
      csr_index  = pdaoa_pkg::CSR_DIFF_MODE;
      csr_data   = '0;
      rsp_stall  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single phase, extremes, half turn, zero and full ratio.
      send_word(16'h7fff, 1'b1);
      send_word(16'h8000, 1'b0);
      send_word(16'h7fff, 1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'h8000, 1'b1);
      write_reg(pdaoa_pkg::CSR_DIFF_MODE, 16'h0000);
      write_reg(pdaoa_pkg::CSR_RATIO, 16'hffff);
      send_snapshot(3, 16'h0000, 16'h1000, 0);
      write_reg(pdaoa_pkg::CSR_RATIO, 16'h0000);
      send_snapshot(2, 16'h1234, 16'h2000, 0);
      write_reg(pdaoa_pkg::CSR_RATIO, 16'h0001);
      write_reg(pdaoa_pkg::CSR_DIFF_MODE, 16'hffff);
      send_snapshot(2, 16'h0000, 16'h4000, 0);
      write_reg(pdaoa_pkg::CSR_RATIO, pdaoa_pkg::RATIO_INIT);
      // Mode flips halfway through a snapshot.
      send_word(16'h0100, 1'b0);
      send_word(16'h0300, 1'b0);
      write_reg(pdaoa_pkg::CSR_DIFF_MODE, 16'h0000);
      send_word(16'h0600, 1'b1);
      write_reg(pdaoa_pkg::CSR_DIFF_MODE, 16'h0001);

      // Random snapshots, mostly well formed phase ramps.
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 7) == 0) no_gaps = ~no_gaps;
         if ($urandom_range(0, 5) == 0) write_reg(pdaoa_pkg::CSR_DIFF_MODE, 16'($urandom));
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
               0:       write_reg(pdaoa_pkg::CSR_RATIO, 16'hffff);
               1:       write_reg(pdaoa_pkg::CSR_RATIO, 16'($urandom_range(0, 2)));
               2:       write_reg(pdaoa_pkg::CSR_RATIO, 16'($urandom));
               default: write_reg(pdaoa_pkg::CSR_RATIO, 16'($urandom_range(2048, 16384)));
            endcase
         end
         case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = $urandom_range(16, 20);
            default: len = $urandom_range(2, 16);
         endcase
         step = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
         if ($urandom_range(0, 9) == 0)
            send_snapshot(len, 16'($urandom), 16'($urandom), 32767);
         else
            send_snapshot(len, 16'($urandom), step, $urandom_range(0, 300));
      end

      req_valid <= 1'b0;
      no_gaps = 1'b0;
      while (sb.angle_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
